/* design/rfs_pkg.sv */
package rfs_pkg;

    // selector carried in s_tuser
    typedef enum logic [1:0] {
        FUNC_ENQUEUE   = 2'd0,
        FUNC_POLL      = 2'd1,
        FUNC_TX_START  = 2'd2,
        FUNC_TX_RESULT = 2'd3
    } func_t;

    // result kind carried in m_tuser
    typedef enum logic [2:0] {
        KIND_QUEUED  = 3'd0,
        KIND_DROPPED = 3'd1,
        KIND_FORWARD = 3'd2,
        KIND_NONE    = 3'd3,
        KIND_TX      = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_SCAN,
        S_DONE
    } ctl_state_t;

    typedef enum logic [1:0] {
        H_IDLE,
        H_MUL_A,
        H_MUL_B,
        H_DIV
    } hash_state_t;

    localparam logic [1:0] CFG_LOCAL_ID  = 2'd0;
    localparam logic [1:0] CFG_MIN_DELAY = 2'd1;
    localparam logic [1:0] CFG_MAX_DELAY = 2'd2;
    localparam logic [1:0] CFG_RELAY_ROLE = 2'd3;

    localparam logic [63:0] RST_LOCAL_ID  = 64'd0;
    localparam logic [15:0] RST_MIN_DELAY = 16'd100;
    localparam logic [15:0] RST_MAX_DELAY = 16'd1000;
    localparam logic        RST_RELAY_ROLE = 1'b1;

    localparam logic [31:0] HASH_MUL_A = 32'h7FEB352D;
    localparam logic [31:0] HASH_MUL_B = 32'h846CA68B;

    // request travelling down the slot chain, one cell per cycle
    typedef struct packed {
        logic        busy;
        logic        poll;   // 1 poll for due slot, 0 store in free slot
        logic        hit;
        logic [31:0] stamp;  // due time on enqueue, current time on poll
        logic [9:0]  rssi;
        logic [7:0]  snr;
        logic [15:0] tag;
    } token_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] delay;
        logic [15:0] tag;
        logic [9:0]  rssi;
        logic [7:0]  snr;
    } result_t;

endpackage

/* design/rfs_hash.sv */
module rfs_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] seed,
    input  logic [31:0] mix_hi,
    input  logic [15:0] min_delay,
    input  logic [15:0] max_delay,
    output logic        done,
    output logic [15:0] delay
);

    localparam int DIV_ITERS = 16;  // two dividend bits per iteration

    rfs_pkg::hash_state_t state_reg, state_next;
    logic [31:0] v_reg, v_next;
    logic        round_reg, round_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] width_reg, width_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [15:0] delay_reg, delay_next;

    logic [31:0] op_a, op_b, prod_a, prod_b;
    logic [31:0] dvd_w;
    logic [16:0] rem_w;
    logic [17:0] trial;

    function automatic logic [31:0] xs16(input logic [31:0] x);
        return x ^ (x >> 16);
    endfunction

    function automatic logic [31:0] xs15(input logic [31:0] x);
        return x ^ (x >> 15);
    endfunction

    // second round folds the high half of the local id in before the shift
    assign op_a   = round_reg ? xs16(xs16(v_reg) ^ mix_hi) : xs16(v_reg);
    assign op_b   = xs15(v_reg);
    assign prod_a = op_a * rfs_pkg::HASH_MUL_A;
    assign prod_b = op_b * rfs_pkg::HASH_MUL_B;

    // restoring remainder, two bits a cycle
    always_comb begin
        rem_w = rem_reg;
        dvd_w = dvd_reg;
        trial = '0;
        for (int i = 0; i < 2; i++) begin
            trial = {rem_w, dvd_w[31]};
            dvd_w = {dvd_w[30:0], 1'b0};
            if (trial >= {1'b0, width_reg}) begin
                trial = trial - {1'b0, width_reg};
            end
            rem_w = trial[16:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        v_next     = v_reg;
        round_next = round_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        width_next = width_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        delay_next = delay_reg;
        case (state_reg)
            rfs_pkg::H_IDLE: begin
                if (start) begin
                    v_next     = seed;
                    round_next = 1'b0;
                    if (max_delay < min_delay) begin
                        width_next = 17'd1;
                    end else begin
                        width_next = {1'b0, max_delay} - {1'b0, min_delay} + 17'd1;
                    end
                    state_next = rfs_pkg::H_MUL_A;
                end
            end
            rfs_pkg::H_MUL_A: begin
                v_next     = prod_a;
                state_next = rfs_pkg::H_MUL_B;
            end
            rfs_pkg::H_MUL_B: begin
                v_next = prod_b;
                if (round_reg) begin
                    dvd_next   = xs16(prod_b);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = rfs_pkg::H_DIV;
                end else begin
                    round_next = 1'b1;
                    state_next = rfs_pkg::H_MUL_A;
                end
            end
            rfs_pkg::H_DIV: begin
                dvd_next = dvd_w;
                rem_next = rem_w;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(DIV_ITERS - 1)) begin
                    delay_next = min_delay + rem_w[15:0];
                    done_next  = 1'b1;
                    state_next = rfs_pkg::H_IDLE;
                end
            end
            default: begin
                state_next = rfs_pkg::H_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rfs_pkg::H_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg     <= v_next;
        round_reg <= round_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        width_reg <= width_next;
        cnt_reg   <= cnt_next;
        delay_reg <= delay_next;
    end

    assign done  = done_reg;
    assign delay = delay_reg;

endmodule

/* design/rfs_cell.sv */
module rfs_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  rfs_pkg::token_t tok_i,
    output rfs_pkg::token_t tok_o
);

    logic        valid_reg, valid_next;
    logic [31:0] due_reg;
    logic [9:0]  rssi_reg;
    logic [7:0]  snr_reg;
    logic [15:0] tag_reg;

    rfs_pkg::token_t tok_reg, tok_next;
    logic [31:0] diff;
    logic        open, take_free, take_due;

    assign diff      = tok_i.stamp - due_reg;
    assign open      = tok_i.busy && !tok_i.hit;
    assign take_free = open && !tok_i.poll && !valid_reg;
    // wrap-aware: due once now - due is non-negative as a signed value
    assign take_due  = open && tok_i.poll && valid_reg && !diff[31];

    always_comb begin
        tok_next   = tok_i;
        valid_next = valid_reg;
        if (take_free) begin
            tok_next.hit = 1'b1;
            valid_next   = 1'b1;
        end
        if (take_due) begin
            tok_next.hit  = 1'b1;
            tok_next.rssi = rssi_reg;
            tok_next.snr  = snr_reg;
            tok_next.tag  = tag_reg;
            valid_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_free) begin
            due_reg  <= tok_i.stamp;
            rssi_reg <= tok_i.rssi;
            snr_reg  <= tok_i.snr;
            tag_reg  <= tok_i.tag;
        end
    end

    assign tok_o = tok_reg;

endmodule

/* design/relay_forward_scheduler.sv */
// Relay forward scheduler with QUEUE_DEPTH slots kept in a chain of cells. One item
// is worked at a time. Transmit items and refused polls go straight to the done
// state, which loads the output register once it is free. A poll sends a request
// down the slot chain, one cell a cycle, and its answer is formed as it leaves the
// last cell. An enqueue first runs the delay hash (four 32x32 multiplies, one a
// cycle, then a remainder unit that takes two bits a cycle), then the chain walk.
// The next input is taken once the result sits in the output register, even if it
// has not been taken yet. Configuration writes go through cfg_wr_en at any time but
// are meant for an idle block.
module relay_forward_scheduler #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          s_tvalid,
    output logic          s_tready,
    // source_id[63:0], sequence_req[95:64], rssi[105:96], snr[113:106],
    // packet_tag[129:114], now_time[161:130], tx_ok[162], zero fill
    input  logic [167:0]  s_tdata,
    // func[1:0]
    input  logic [1:0]    s_tuser,

    output logic          m_tvalid,
    input  logic          m_tready,
    // delay_ms[15:0], out_tag[31:16], out_rssi[41:32], out_snr[49:42],
    // queue_count[53:50], zero fill
    output logic [55:0]   m_tdata,
    // kind[2:0]
    output logic [2:0]    m_tuser,

    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [63:0]   cfg_wdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // configuration
    logic [63:0] local_id_reg;
    logic [15:0] min_delay_reg;
    logic [15:0] max_delay_reg;
    logic        relay_role_reg;

    // input unpack
    rfs_pkg::func_t in_func;
    logic [63:0] in_src;
    logic [31:0] in_seq;
    logic [9:0]  in_rssi;
    logic [7:0]  in_snr;
    logic [15:0] in_tag;
    logic [31:0] in_now;

    assign in_func = rfs_pkg::func_t'(s_tuser);
    assign in_src  = s_tdata[63:0];
    assign in_seq  = s_tdata[95:64];
    assign in_rssi = s_tdata[105:96];
    assign in_snr  = s_tdata[113:106];
    assign in_tag  = s_tdata[129:114];
    assign in_now  = s_tdata[161:130];

    rfs_pkg::ctl_state_t state_reg, state_next;
    logic             tx_active_reg, tx_active_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W+3:0] count_ext;
    logic [31:0]      now_reg, now_next;
    logic [9:0]       rssi_reg, rssi_next;
    logic [7:0]       snr_reg, snr_next;
    logic [15:0]      tag_reg, tag_next;
    logic [15:0]      dly_reg, dly_next;
    rfs_pkg::token_t  launch_reg, launch_next;
    rfs_pkg::result_t res_reg, res_next;
    logic             m_valid_reg, m_valid_next;
    rfs_pkg::result_t m_res_reg, m_res_next;
    logic [3:0]       m_cnt_reg, m_cnt_next;

    logic        hash_start;
    logic [31:0] hash_seed;
    logic        hash_done;
    logic [15:0] hash_delay;

    rfs_pkg::token_t tok_chain [QUEUE_DEPTH+1];
    rfs_pkg::token_t chain_end;

    assign hash_seed = in_src[31:0] ^ in_src[63:32] ^ in_seq ^ local_id_reg[31:0];

    rfs_hash u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (hash_start),
        .seed      (hash_seed),
        .mix_hi    (local_id_reg[63:32]),
        .min_delay (min_delay_reg),
        .max_delay (max_delay_reg),
        .done      (hash_done),
        .delay     (hash_delay)
    );

    assign tok_chain[0] = launch_reg;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
        rfs_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_i   (tok_chain[g]),
            .tok_o   (tok_chain[g+1])
        );
    end

    assign chain_end = tok_chain[QUEUE_DEPTH];
    assign count_ext = {4'b0000, count_reg};

    always_comb begin
        state_next     = state_reg;
        tx_active_next = tx_active_reg;
        count_next     = count_reg;
        now_next       = now_reg;
        rssi_next      = rssi_reg;
        snr_next       = snr_reg;
        tag_next       = tag_reg;
        dly_next       = dly_reg;
        launch_next    = '0;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_res_next     = m_res_reg;
        m_cnt_next     = m_cnt_reg;
        hash_start     = 1'b0;
        s_tready       = (state_reg == rfs_pkg::S_IDLE);
        case (state_reg)
            rfs_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    now_next  = in_now;
                    rssi_next = in_rssi;
                    snr_next  = in_snr;
                    tag_next  = in_tag;
                    res_next  = '{kind: rfs_pkg::KIND_TX, default: '0};
                    case (in_func)
                        rfs_pkg::FUNC_ENQUEUE: begin
                            hash_start = 1'b1;
                            state_next = rfs_pkg::S_HASH;
                        end
                        rfs_pkg::FUNC_POLL: begin
                            if (relay_role_reg && !tx_active_reg) begin
                                launch_next.busy  = 1'b1;
                                launch_next.poll  = 1'b1;
                                launch_next.stamp = in_now;
                                state_next        = rfs_pkg::S_SCAN;
                            end else begin
                                res_next   = '{kind: rfs_pkg::KIND_NONE, default: '0};
                                state_next = rfs_pkg::S_DONE;
                            end
                        end
                        rfs_pkg::FUNC_TX_START: begin
                            tx_active_next = 1'b1;
                            state_next     = rfs_pkg::S_DONE;
                        end
                        rfs_pkg::FUNC_TX_RESULT: begin
                            tx_active_next = 1'b0;
                            state_next     = rfs_pkg::S_DONE;
                        end
                        default: begin
                            state_next = rfs_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            rfs_pkg::S_HASH: begin
                if (hash_done) begin
                    dly_next          = hash_delay;
                    launch_next.busy  = 1'b1;
                    launch_next.stamp = now_reg + {16'd0, hash_delay};
                    launch_next.rssi  = rssi_reg;
                    launch_next.snr   = snr_reg;
                    launch_next.tag   = tag_reg;
                    state_next        = rfs_pkg::S_SCAN;
                end
            end
            rfs_pkg::S_SCAN: begin
                if (chain_end.busy) begin
                    res_next = '{kind: rfs_pkg::KIND_NONE, default: '0};
                    if (chain_end.poll) begin
                        if (chain_end.hit) begin
                            res_next.kind = rfs_pkg::KIND_FORWARD;
                            res_next.tag  = chain_end.tag;
                            res_next.rssi = chain_end.rssi;
                            res_next.snr  = chain_end.snr;
                            count_next    = count_reg - CNT_W'(1);
                        end
                    end else begin
                        res_next.delay = dly_reg;
                        if (chain_end.hit) begin
                            res_next.kind = rfs_pkg::KIND_QUEUED;
                            count_next    = count_reg + CNT_W'(1);
                        end else begin
                            res_next.kind = rfs_pkg::KIND_DROPPED;
                        end
                    end
                    state_next = rfs_pkg::S_DONE;
                end
            end
            rfs_pkg::S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    m_cnt_next   = count_ext[3:0];
                    state_next   = rfs_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rfs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rfs_pkg::S_IDLE;
            tx_active_reg <= 1'b0;
            count_reg     <= '0;
            launch_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tx_active_reg <= tx_active_next;
            count_reg     <= count_next;
            launch_reg    <= launch_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg   <= now_next;
        rssi_reg  <= rssi_next;
        snr_reg   <= snr_next;
        tag_reg   <= tag_next;
        dly_reg   <= dly_next;
        res_reg   <= res_next;
        m_res_reg <= m_res_next;
        m_cnt_reg <= m_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_id_reg   <= rfs_pkg::RST_LOCAL_ID;
            min_delay_reg  <= rfs_pkg::RST_MIN_DELAY;
            max_delay_reg  <= rfs_pkg::RST_MAX_DELAY;
            relay_role_reg <= rfs_pkg::RST_RELAY_ROLE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rfs_pkg::CFG_LOCAL_ID:   local_id_reg   <= cfg_wdata;
                rfs_pkg::CFG_MIN_DELAY:  min_delay_reg  <= cfg_wdata[15:0];
                rfs_pkg::CFG_MAX_DELAY:  max_delay_reg  <= cfg_wdata[15:0];
                rfs_pkg::CFG_RELAY_ROLE: relay_role_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_cnt_reg, m_res_reg.snr, m_res_reg.rssi,
                       m_res_reg.tag, m_res_reg.delay};
    assign m_tuser  = m_res_reg.kind;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("slot count above queue depth");

    a_chain_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_end.busy |-> state_reg == rfs_pkg::S_SCAN)
        else $error("request left the slot chain outside the scan state");

    a_hash_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        hash_done |-> state_reg == rfs_pkg::S_HASH)
        else $error("hash finished while not waiting for it");

    a_forward_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rfs_pkg::S_SCAN && chain_end.busy && chain_end.poll && chain_end.hit)
        |-> count_reg != '0)
        else $error("forward issued from an empty queue");

endmodule

/* bench/tb_relay_forward_scheduler.sv */
module tb_relay_forward_scheduler;

    localparam int SLOTS = 8;
    localparam int SETTLE = SLOTS + 32;
    localparam int LIMIT = 1000000;

    typedef struct {
        rfs_pkg::func_t func;
        logic [63:0] src;
        logic [31:0] seq;
        logic [9:0]  rssi;
        logic [7:0]  snr;
        logic [15:0] tag;
        logic [31:0] now;
        logic        tx_ok;
    } relay_req_t;

    typedef struct {
        rfs_pkg::kind_t kind;
        logic [15:0] delay;
        logic [15:0] tag;
        logic [9:0]  rssi;
        logic [7:0]  snr;
        logic [3:0]  count;
    } relay_resp_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [167:0]  s_tdata = '0;
    logic [1:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [55:0]   m_tdata;
    logic [2:0]    m_tuser;
    logic          cfg_wr_en = 1'b0;
    logic [1:0]    cfg_index = '0;
    logic [63:0]   cfg_wdata = '0;

    relay_forward_scheduler #(.QUEUE_DEPTH(SLOTS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // scheduler mirror: settings and slot contents
    logic [63:0] my_id;
    logic [15:0] win_min, win_max;
    logic        relay_on;
    logic        q_used [SLOTS];
    logic [31:0] q_due  [SLOTS];
    logic [9:0]  q_rssi [SLOTS];
    logic [7:0]  q_snr  [SLOTS];
    logic [15:0] q_tag  [SLOTS];
    logic [3:0]  q_count;
    logic        tx_busy;

    relay_req_t  rx_packets[$];
    relay_resp_t sched_answers[$];
    relay_req_t  cur_req;

    int errors = 0;
    int rx_count = 0;
    int cycles = 0;
    int gap_max = 0;
    int stall_mode = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int next_hold_at = 300;
    int stall_tick = 0;

    function automatic logic [31:0] mix32(logic [31:0] v);
        logic [31:0] x;
        x = v ^ (v >> 16);
        x = x * rfs_pkg::HASH_MUL_A;
        x = x ^ (x >> 15);
        x = x * rfs_pkg::HASH_MUL_B;
        x = x ^ (x >> 16);
        return x;
    endfunction

    function automatic logic [15:0] hop_delay(logic [63:0] src, logic [31:0] seq);
        logic [31:0] h;
        logic [31:0] width;
        logic [31:0] d;
        h = src[31:0] ^ src[63:32] ^ seq;
        h = mix32(h ^ my_id[31:0]);
        h = mix32(h ^ my_id[63:32]);
        width = (win_max < win_min) ? 32'd1 : 32'(win_max) - 32'(win_min) + 32'd1;
        d = 32'(win_min) + h % width;
        return d[15:0];
    endfunction

    function automatic relay_resp_t schedule_step(relay_req_t r);
        relay_resp_t a;
        logic [31:0] lag;
        bit done;
        a.kind = rfs_pkg::KIND_NONE;
        a.delay = '0;
        a.tag = '0;
        a.rssi = '0;
        a.snr = '0;
        done = 0;
        case (r.func)
            rfs_pkg::FUNC_ENQUEUE: begin
                a.delay = hop_delay(r.src, r.seq);
                a.kind = rfs_pkg::KIND_DROPPED;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!done && !q_used[i]) begin
                        q_used[i] = 1'b1;
                        q_due[i] = r.now + 32'(a.delay);
                        q_rssi[i] = r.rssi;
                        q_snr[i] = r.snr;
                        q_tag[i] = r.tag;
                        q_count = q_count + 4'd1;
                        a.kind = rfs_pkg::KIND_QUEUED;
                        done = 1;
                    end
                end
            end
            rfs_pkg::FUNC_POLL: begin
                if (relay_on && !tx_busy) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        lag = r.now - q_due[i];
                        // wrap-aware: due once the difference is non-negative
                        if (!done && q_used[i] && !lag[31]) begin
                            a.tag = q_tag[i];
                            a.rssi = q_rssi[i];
                            a.snr = q_snr[i];
                            q_used[i] = 1'b0;
                            if (q_count != 0) q_count = q_count - 4'd1;
                            a.kind = rfs_pkg::KIND_FORWARD;
                            done = 1;
                        end
                    end
                end
            end
            rfs_pkg::FUNC_TX_START: begin
                tx_busy = 1'b1;
                a.kind = rfs_pkg::KIND_TX;
            end
            default: begin
                tx_busy = 1'b0;
                a.kind = rfs_pkg::KIND_TX;
            end
        endcase
        a.count = q_count;
        return a;
    endfunction

    function automatic relay_req_t rand_req(rfs_pkg::func_t f);
        relay_req_t r;
        r.func = f;
        r.src = {$urandom, $urandom};
        r.seq = $urandom;
        r.rssi = 10'($urandom);
        r.snr = 8'($urandom);
        r.tag = 16'($urandom);
        r.now = $urandom;
        r.tx_ok = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    task automatic load_settings(logic [63:0] id, logic [15:0] lo, logic [15:0] hi, logic role);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= rfs_pkg::CFG_LOCAL_ID;
        cfg_wdata <= id;
        @(posedge aclk);
        cfg_index <= rfs_pkg::CFG_MIN_DELAY;
        cfg_wdata <= {48'd0, lo};
        @(posedge aclk);
        cfg_index <= rfs_pkg::CFG_MAX_DELAY;
        cfg_wdata <= {48'd0, hi};
        @(posedge aclk);
        cfg_index <= rfs_pkg::CFG_RELAY_ROLE;
        cfg_wdata <= {63'd0, role};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        my_id = id;
        win_min = lo;
        win_max = hi;
        relay_on = role;
    endtask

    // wait for the block to go quiet before touching the settings
    // sampled between edges so the sender's updates at the edge are settled
    task automatic drain();
        while (rx_packets.size() != 0 || s_tvalid || sched_answers.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // sender: bursts of transfers separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) sched_answers.push_back(schedule_step(cur_req));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (rx_packets.size() != 0) begin
                    cur_req = rx_packets.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'd0, cur_req.tx_ok, cur_req.now, cur_req.tag, cur_req.snr,
                                cur_req.rssi, cur_req.seq, cur_req.src};
                    s_tuser <= cur_req.func;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure, with a few long hold-offs to fill the block
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rx_count >= next_hold_at) begin
            hold_left = 200;
            next_hold_at = next_hold_at + 700;
            m_tready <= 1'b0;
        end else begin
            stall_tick++;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 9) < 3);
                default: m_tready <= ((stall_tick % 7) < 4);
            endcase
        end
    end

    always @(posedge aclk) begin : result_check
        relay_resp_t a;
        if (aresetn && m_tvalid && m_tready) begin
            if (sched_answers.size() == 0) begin
                $error("result with no request pending: kind %0d", m_tuser);
                errors++;
            end else begin
                a = sched_answers.pop_front();
                check_field("kind", 32'(a.kind), 32'(m_tuser));
                check_field("delay_ms", 32'(a.delay), 32'(m_tdata[15:0]));
                check_field("out_tag", 32'(a.tag), 32'(m_tdata[31:16]));
                check_field("out_rssi", 32'(a.rssi), 32'(m_tdata[41:32]));
                check_field("out_snr", 32'(a.snr), 32'(m_tdata[49:42]));
                check_field("queue_count", 32'(a.count), 32'(m_tdata[53:50]));
            end
            rx_count <= rx_count + 1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        relay_req_t r;
        logic [31:0] t_now;
        logic [31:0] t0;
        logic [15:0] lo, hi;
        logic [63:0] id;
        logic role;
        int n_items, enq_pct, step, p, pf;

        my_id = rfs_pkg::RST_LOCAL_ID;
        win_min = rfs_pkg::RST_MIN_DELAY;
        win_max = rfs_pkg::RST_MAX_DELAY;
        relay_on = rfs_pkg::RST_RELAY_ROLE;
        for (int i = 0; i < SLOTS; i++) q_used[i] = 1'b0;
        q_count = '0;
        tx_busy = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // field extremes on enqueue, then fill until the queue drops
        r = rand_req(rfs_pkg::FUNC_ENQUEUE);
        r.src = '1; r.seq = '0; r.rssi = 10'h200; r.snr = 8'h80;
        r.tag = '1; r.now = '1; r.tx_ok = 1'b1;
        rx_packets.push_back(r);
        r = rand_req(rfs_pkg::FUNC_ENQUEUE);
        r.src = '0; r.seq = '1; r.rssi = 10'h1FF; r.snr = 8'h7F;
        r.tag = '0; r.now = '0; r.tx_ok = 1'b0;
        rx_packets.push_back(r);
        for (int i = 0; i < 7; i++) begin
            r = rand_req(rfs_pkg::FUNC_ENQUEUE);
            r.now = '0;
            rx_packets.push_back(r);
        end
        // nothing due yet
        r = rand_req(rfs_pkg::FUNC_POLL); r.now = '0; rx_packets.push_back(r);
        // poll refused while a transmission is active
        r = rand_req(rfs_pkg::FUNC_TX_START); rx_packets.push_back(r);
        r = rand_req(rfs_pkg::FUNC_POLL); r.now = 32'd5000; rx_packets.push_back(r);
        r = rand_req(rfs_pkg::FUNC_TX_RESULT); r.tx_ok = 1'b0; rx_packets.push_back(r);
        r = rand_req(rfs_pkg::FUNC_POLL); r.now = 32'd5000; rx_packets.push_back(r);
        drain();

        // outside relay role: polls refused, enqueue still works
        load_settings(rfs_pkg::RST_LOCAL_ID, rfs_pkg::RST_MIN_DELAY, rfs_pkg::RST_MAX_DELAY,
                      1'b0);
        r = rand_req(rfs_pkg::FUNC_POLL); r.now = 32'd5000; rx_packets.push_back(r);
        r = rand_req(rfs_pkg::FUNC_ENQUEUE); r.now = '0; rx_packets.push_back(r);
        drain();

        load_settings({$urandom, $urandom}, 16'd500, 16'd100, 1'b1);
        for (int i = 0; i < SLOTS; i++) begin
            r = rand_req(rfs_pkg::FUNC_POLL);
            r.now = 32'd5000;
            rx_packets.push_back(r);
        end
        // inverted window gives the minimum; due time wraps past zero
        t0 = 32'hFFFF_FF00;
        r = rand_req(rfs_pkg::FUNC_ENQUEUE); r.now = t0; rx_packets.push_back(r);
        r = rand_req(rfs_pkg::FUNC_POLL); r.now = t0 + 32'd499; rx_packets.push_back(r);
        r = rand_req(rfs_pkg::FUNC_POLL); r.now = t0 + 32'd500; rx_packets.push_back(r);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            id = {$urandom, $urandom};
            role = 1'b1;
            n_items = 270;
            case (ph)
                0: begin lo = 16'd100; hi = 16'd1000; end
                1: begin id = '1; lo = 16'd0; hi = 16'd0; end
                2: begin id = '0; lo = 16'd0; hi = 16'hFFFF; end
                3: begin lo = 16'hFFFF; hi = 16'hFFFF; end
                4: begin lo = 16'hFFFF; hi = 16'd0; end
                5: begin
                    lo = 16'($urandom_range(0, 200));
                    hi = lo + 16'($urandom_range(0, 300));
                    role = 1'b0;
                    n_items = 100;
                end
                default: begin
                    lo = 16'($urandom_range(0, 1000));
                    hi = lo + 16'($urandom_range(0, 1000));
                end
            endcase
            load_settings(id, lo, hi, role);
            gap_max = (ph % 3 == 0) ? 0 : ph * 6;
            stall_mode = ph % 4;
            enq_pct = 35 + 5 * (ph % 4);
            step = ((win_max > win_min) ? int'(win_max) : int'(win_min)) / 4 + 2;
            t_now = $urandom;

            for (int k = 0; k < n_items; k++) begin
                pf = $urandom_range(0, 99);
                if (pf < enq_pct) r = rand_req(rfs_pkg::FUNC_ENQUEUE);
                else if (pf < enq_pct + 8) r = rand_req(rfs_pkg::FUNC_TX_START);
                else if (pf < enq_pct + 16) r = rand_req(rfs_pkg::FUNC_TX_RESULT);
                else r = rand_req(rfs_pkg::FUNC_POLL);
                p = $urandom_range(0, 99);
                if (p == 0) begin
                    // jump about half the time range to exercise the wrap compare
                    t_now = t_now + 32'h7FFF_FFF0 + $urandom_range(0, 64);
                    r.now = t_now;
                end else if (p > 3) begin
                    t_now = t_now + $urandom_range(0, step);
                    r.now = t_now;
                end
                rx_packets.push_back(r);
            end
            drain();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
